[rtl/thi_pkg.sv]
// shared constants, codes and pipeline record types for the terrain height interpolator
// no dependencies; every other file refers to it by scoped names
`timescale 1ns / 1ps

package thi_pkg;

    localparam int MAX_GRID_POINTS = 256;
    localparam int GRID_W          = $clog2(MAX_GRID_POINTS);
    localparam int BANK_DEPTH      = (MAX_GRID_POINTS * MAX_GRID_POINTS) / 4;
    localparam int BANK_AW         = $clog2(BANK_DEPTH);
    localparam int H_W             = 24;
    localparam int POS_W           = 21;
    localparam int UD_W            = 16;
    localparam int MS_W            = 9;
    localparam int FRAC_W          = 16;
    localparam int QUO_W           = POS_W + FRAC_W;
    localparam int RAT_W           = FRAC_W + 1;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OBJ = 2'd1;
    localparam logic [1:0] ST_NEG = 2'd2;
    localparam logic [1:0] ST_OUT = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_UNIT_DIST = 1'b0;
    localparam logic CFG_MAP_SIZE  = 1'b1;

    // triangle of the cell that holds the point
    typedef enum logic [1:0] {
        TRI_ODD_LOW,
        TRI_ODD_HIGH,
        TRI_EVEN_UPPER,
        TRI_EVEN_LOWER
    } t_tri;

    // corner of a cell as {dx, dz}
    localparam logic [1:0] CRN_00 = 2'b00;
    localparam logic [1:0] CRN_01 = 2'b01;
    localparam logic [1:0] CRN_10 = 2'b10;
    localparam logic [1:0] CRN_11 = 2'b11;

    // item record alongside the coordinate dividers
    typedef struct packed {
        logic              op;
        logic              px_neg;
        logic              pz_neg;
        logic [GRID_W-1:0] sx;
        logic [GRID_W-1:0] sz;
        logic [H_W-1:0]    sh;
        logic [H_W-1:0]    oh;
        logic              ov;
    } t_front;

    // item record alongside the ratio divider and memory access
    typedef struct packed {
        logic              op;
        logic [1:0]        status;
        t_tri              tri_sel;
        logic [GRID_W-1:0] ix;
        logic [GRID_W-1:0] iz;
        logic [FRAC_W-1:0] fx;
        logic [GRID_W-1:0] sx;
        logic [GRID_W-1:0] sz;
        logic [H_W-1:0]    sh;
        logic [H_W-1:0]    oh;
        logic              ov;
    } t_back;

    // item record for the interpolation tail
    typedef struct packed {
        logic             op;
        logic [1:0]       status;
        logic [H_W-1:0]   oh;
        logic             ov;
        logic [RAT_W-1:0] ratio;
    } t_tail;

endpackage

[rtl/thi_coord_div.sv]
// pipelined restoring divider, one quotient bit per stage: (dividend << 16) / divisor
// depends on thi_pkg for widths
`timescale 1ns / 1ps

module thi_coord_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [thi_pkg::POS_W-1:0]     i_dividend,
    input  logic [thi_pkg::UD_W-1:0]      i_divisor,
    output logic [thi_pkg::QUO_W-1:0]     o_quot
);

    localparam int NST = thi_pkg::QUO_W;

    logic [thi_pkg::QUO_W-1:0] r_w [0:NST-1];
    logic [thi_pkg::UD_W-1:0]  r_r [0:NST-1];
    logic [thi_pkg::UD_W-1:0]  r_d [0:NST-1];
    logic [thi_pkg::QUO_W-1:0] n_w [0:NST-1];
    logic [thi_pkg::UD_W-1:0]  n_r [0:NST-1];
    logic [thi_pkg::UD_W-1:0]  n_d [0:NST-1];

    // one shift-compare-subtract per stage
    always_comb begin
        logic [thi_pkg::QUO_W-1:0] src_w;
        logic [thi_pkg::UD_W-1:0]  src_r;
        logic [thi_pkg::UD_W-1:0]  src_d;
        logic [thi_pkg::UD_W:0]    t;
        logic                      ge;
        for (int s = 0; s < NST; s++) begin
            if (s == 0) begin
                src_w = {i_dividend, {thi_pkg::FRAC_W{1'b0}}};
                src_r = '0;
                src_d = i_divisor;
            end else begin
                src_w = r_w[s-1];
                src_r = r_r[s-1];
                src_d = r_d[s-1];
            end
            t  = {src_r, src_w[thi_pkg::QUO_W-1]};
            ge = t >= {1'b0, src_d};
            n_r[s] = ge ? thi_pkg::UD_W'(t - {1'b0, src_d}) : t[thi_pkg::UD_W-1:0];
            n_w[s] = {src_w[thi_pkg::QUO_W-2:0], ge};
            n_d[s] = src_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NST; s++) begin
                r_w[s] <= n_w[s];
                r_r[s] <= n_r[s];
                r_d[s] <= n_d[s];
            end
        end
    end

    assign o_quot = r_w[NST-1];

endmodule

[rtl/thi_ratio_div.sv]
// pipelined restoring divider for interpolation ratios: (num << 16) / den, num <= den
// depends on thi_pkg for widths
`timescale 1ns / 1ps

module thi_ratio_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [thi_pkg::RAT_W-1:0] i_num,
    input  logic [thi_pkg::RAT_W-1:0] i_den,
    output logic [thi_pkg::RAT_W-1:0] o_ratio
);

    localparam int NST = thi_pkg::RAT_W;

    logic [thi_pkg::RAT_W:0]   r_r [0:NST-1];
    logic [thi_pkg::RAT_W-1:0] r_q [0:NST-1];
    logic [thi_pkg::RAT_W-1:0] r_d [0:NST-1];
    logic [thi_pkg::RAT_W:0]   n_r [0:NST-1];
    logic [thi_pkg::RAT_W-1:0] n_q [0:NST-1];
    logic [thi_pkg::RAT_W-1:0] n_d [0:NST-1];

    // compare, subtract, double the partial remainder
    always_comb begin
        logic [thi_pkg::RAT_W:0]   src_r;
        logic [thi_pkg::RAT_W-1:0] src_q;
        logic [thi_pkg::RAT_W-1:0] src_d;
        logic [thi_pkg::RAT_W:0]   sub;
        logic                      ge;
        for (int s = 0; s < NST; s++) begin
            if (s == 0) begin
                src_r = {1'b0, i_num};
                src_q = '0;
                src_d = i_den;
            end else begin
                src_r = r_r[s-1];
                src_q = r_q[s-1];
                src_d = r_d[s-1];
            end
            ge     = src_r >= {1'b0, src_d};
            sub    = ge ? (src_r - {1'b0, src_d}) : src_r;
            n_r[s] = {sub[thi_pkg::RAT_W-1:0], 1'b0};
            n_q[s] = {src_q[thi_pkg::RAT_W-2:0], ge};
            n_d[s] = src_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NST; s++) begin
                r_r[s] <= n_r[s];
                r_q[s] <= n_q[s];
                r_d[s] <= n_d[s];
            end
        end
    end

    assign o_ratio = r_q[NST-1];

endmodule

[rtl/thi_bank.sv]
// one height bank: a quarter of the grid selected by column and row parity
// synchronous single port, registered read; depends on thi_pkg
`timescale 1ns / 1ps

module thi_bank (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic                        i_we,
    input  logic [thi_pkg::BANK_AW-1:0] i_addr,
    input  logic [thi_pkg::H_W-1:0]     i_wdata,
    output logic [thi_pkg::H_W-1:0]     o_rdata
);

    logic [thi_pkg::H_W-1:0] mem [0:thi_pkg::BANK_DEPTH-1];
    logic [thi_pkg::H_W-1:0] r_q;

    // write or read, data held while stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                mem[i_addr] <= i_wdata;
            end else begin
                r_q <= mem[i_addr];
            end
        end
    end

    assign o_rdata = r_q;

endmodule

[rtl/terrain_height_interpolator_core.sv]
// terrain height interpolator top level: divider pipelines, banked height store, lerp tail
// depends on thi_pkg, thi_coord_div, thi_ratio_div, thi_bank
`timescale 1ns / 1ps

// Usage:
//  Input stream (s side): tuser carries the opcode (write sample or height query), tdata
//  the sample and query fields. A write stores one height; a query returns the height
//  interpolated over the triangle of the grid cell holding (pos_x, pos_z).
//  Output stream (m side): one transfer per input transfer, in order; tdata holds the
//  height, tuser the status.
//  Config channel: index 0 is unit_dist, index 1 is map_size; always ready. Write it only
//  while no item is in flight.
//  Throughput: one item per cycle while the receiver keeps up. An item passes the
//  37-stage coordinate divider, a range-check register, the 17-stage ratio divider,
//  the registered bank read and four multiply/add stages, the last being the output register.
//  Heights live in four parity banks so the four corners of a cell read in the same cycle;
//  writes pass down the same pipeline and reach the banks in item order.
//  Reset empties the pipeline and loads unit_dist 1024 and map_size 256; the height store
//  is not cleared and holds nothing meaningful until written.
//  When the receiver stalls with a result waiting, the whole pipeline holds and the input
//  side deasserts ready.

module terrain_height_interpolator_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: sample_x[7:0], sample_z[15:8], sample_height[39:16], pos_x[60:40],
    //        pos_z[81:61], object_height[105:82], object_height_valid[106], zero pad
    input  logic [111:0] i_s_tdata,
    // tuser: opcode
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: height[23:0]
    output logic [23:0]  o_m_tdata,
    // tuser: status[1:0]
    output logic [1:0]   o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    localparam int NF = thi_pkg::QUO_W;
    localparam int NB = thi_pkg::RAT_W;
    localparam logic [thi_pkg::RAT_W-1:0] ONE = thi_pkg::RAT_W'(1 << thi_pkg::FRAC_W);
    localparam logic [thi_pkg::MS_W-1:0]  MS_MAX = thi_pkg::MS_W'(thi_pkg::MAX_GRID_POINTS);

    logic adv;

    // configuration registers
    logic [thi_pkg::UD_W-1:0] r_unit_dist;
    logic [thi_pkg::MS_W-1:0] r_map_size;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_dist <= thi_pkg::UD_W'(1024);
            r_map_size  <= MS_MAX;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                thi_pkg::CFG_UNIT_DIST: r_unit_dist <= i_cfg_data;
                thi_pkg::CFG_MAP_SIZE:  r_map_size  <= i_cfg_data[thi_pkg::MS_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves when the output register can take a result
    assign adv        = !o_m_tvalid || i_m_tready;
    assign o_s_tready = adv;

    // input unpacking
    logic [thi_pkg::POS_W-1:0] in_px;
    logic [thi_pkg::POS_W-1:0] in_pz;
    logic [thi_pkg::POS_W-1:0] ax;
    logic [thi_pkg::POS_W-1:0] az;
    thi_pkg::t_front           in_f;

    assign in_px     = i_s_tdata[60:40];
    assign in_pz     = i_s_tdata[81:61];
    assign in_f.op     = i_s_tuser;
    assign in_f.px_neg = in_px[thi_pkg::POS_W-1];
    assign in_f.pz_neg = in_pz[thi_pkg::POS_W-1];
    assign in_f.sx     = i_s_tdata[7:0];
    assign in_f.sz     = i_s_tdata[15:8];
    assign in_f.sh     = i_s_tdata[39:16];
    assign in_f.oh     = i_s_tdata[105:82];
    assign in_f.ov     = i_s_tdata[106];
    assign ax = in_f.px_neg ? thi_pkg::POS_W'(-in_px) : in_px;
    assign az = in_f.pz_neg ? thi_pkg::POS_W'(-in_pz) : in_pz;

    // coordinate dividers: cell index in the top bits, fraction in the low 16
    logic [thi_pkg::QUO_W-1:0] qx;
    logic [thi_pkg::QUO_W-1:0] qz;

    thi_coord_div u_div_x (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_dividend (ax),
        .i_divisor  (r_unit_dist),
        .o_quot     (qx)
    );

    thi_coord_div u_div_z (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_dividend (az),
        .i_divisor  (r_unit_dist),
        .o_quot     (qz)
    );

    // item records beside the coordinate dividers
    thi_pkg::t_front r_f  [0:NF-1];
    logic [NF-1:0]   r_fv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (adv) begin
            r_fv <= {r_fv[NF-2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f[0] <= in_f;
            for (int s = 1; s < NF; s++) begin
                r_f[s] <= r_f[s-1];
            end
        end
    end

    // range checks, triangle choice and ratio operands
    thi_pkg::t_front           fo;
    logic [thi_pkg::POS_W-1:0] ix_w;
    logic [thi_pkg::POS_W-1:0] iz_w;
    logic [thi_pkg::FRAC_W-1:0] fx;
    logic [thi_pkg::FRAC_W-1:0] fz;
    logic [thi_pkg::MS_W-1:0]  ms;
    logic [thi_pkg::MS_W-1:0]  lim;
    logic [thi_pkg::RAT_W-1:0] fsum;
    thi_pkg::t_back            n_c;
    logic [thi_pkg::RAT_W-1:0] n_num;
    logic [thi_pkg::RAT_W-1:0] n_den;

    assign fo   = r_f[NF-1];
    assign ix_w = qx[thi_pkg::QUO_W-1:thi_pkg::FRAC_W];
    assign iz_w = qz[thi_pkg::QUO_W-1:thi_pkg::FRAC_W];
    assign fx   = qx[thi_pkg::FRAC_W-1:0];
    assign fz   = qz[thi_pkg::FRAC_W-1:0];
    assign ms   = (r_map_size > MS_MAX) ? MS_MAX : r_map_size;
    assign lim  = ms - thi_pkg::MS_W'(2);
    assign fsum = {1'b0, fx} + {1'b0, fz};

    always_comb begin
        n_c.op = fo.op;
        n_c.ix = ix_w[thi_pkg::GRID_W-1:0];
        n_c.iz = iz_w[thi_pkg::GRID_W-1:0];
        n_c.fx = fx;
        n_c.sx = fo.sx;
        n_c.sz = fo.sz;
        n_c.sh = fo.sh;
        n_c.oh = fo.oh;
        n_c.ov = fo.ov;
        if (r_unit_dist == '0) begin
            n_c.status = thi_pkg::ST_OUT;
        end else if ((fo.px_neg && fx != '0) || (fo.pz_neg && fz != '0)) begin
            n_c.status = thi_pkg::ST_NEG;
        end else if (fo.px_neg || fo.pz_neg || ms < thi_pkg::MS_W'(2)) begin
            n_c.status = thi_pkg::ST_OUT;
        end else if (ix_w > thi_pkg::POS_W'(lim) || iz_w > thi_pkg::POS_W'(lim)) begin
            n_c.status = thi_pkg::ST_OUT;
        end else begin
            n_c.status = thi_pkg::ST_OK;
        end
        if (ix_w[0] ^ iz_w[0]) begin
            n_c.tri_sel = fsum[thi_pkg::FRAC_W] ? thi_pkg::TRI_ODD_HIGH : thi_pkg::TRI_ODD_LOW;
        end else begin
            n_c.tri_sel = (fz > fx) ? thi_pkg::TRI_EVEN_UPPER : thi_pkg::TRI_EVEN_LOWER;
        end
        case (n_c.tri_sel)
            thi_pkg::TRI_ODD_LOW: begin
                n_num = {1'b0, fz};
                n_den = ONE - {1'b0, fx};
            end
            thi_pkg::TRI_ODD_HIGH: begin
                n_num = ONE - {1'b0, fz};
                n_den = {1'b0, fx};
            end
            thi_pkg::TRI_EVEN_UPPER: begin
                n_num = ONE - {1'b0, fz};
                n_den = ONE - {1'b0, fx};
            end
            default: begin
                n_num = {1'b0, fz};
                n_den = {1'b0, fx};
            end
        endcase
    end

    thi_pkg::t_back            r_c;
    logic                      r_cv;
    logic [thi_pkg::RAT_W-1:0] r_num;
    logic [thi_pkg::RAT_W-1:0] r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else if (adv) begin
            r_cv <= r_fv[NF-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c   <= n_c;
            r_num <= n_num;
            r_den <= n_den;
        end
    end

    // ratio divider with item records beside it
    logic [thi_pkg::RAT_W-1:0] ratio;

    thi_ratio_div u_ratio (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_ratio (ratio)
    );

    thi_pkg::t_back r_b  [0:NB-1];
    logic [NB-1:0]  r_bv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (adv) begin
            r_bv <= {r_bv[NB-2:0], r_cv};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b[0] <= r_c;
            for (int s = 1; s < NB; s++) begin
                r_b[s] <= r_b[s-1];
            end
        end
    end

    // bank access: one corner per parity bank, or the sample write
    thi_pkg::t_back             bo;
    logic                       bo_wr;
    logic [thi_pkg::BANK_AW-1:0] bank_addr [0:3];
    logic [3:0]                 bank_we;
    logic [thi_pkg::H_W-1:0]    bank_rd   [0:3];

    assign bo    = r_b[NB-1];
    assign bo_wr = r_bv[NB-1] && (bo.op == thi_pkg::OP_WRITE);

    always_comb begin
        logic [thi_pkg::GRID_W-1:0] cx;
        logic [thi_pkg::GRID_W-1:0] cz;
        for (int b = 0; b < 4; b++) begin
            cx = bo.ix + thi_pkg::GRID_W'(((b >> 1) & 1) ^ int'(bo.ix[0]));
            cz = bo.iz + thi_pkg::GRID_W'((b & 1) ^ int'(bo.iz[0]));
            if (bo.op == thi_pkg::OP_WRITE) begin
                bank_addr[b] = {bo.sx[thi_pkg::GRID_W-1:1], bo.sz[thi_pkg::GRID_W-1:1]};
            end else begin
                bank_addr[b] = {cx[thi_pkg::GRID_W-1:1], cz[thi_pkg::GRID_W-1:1]};
            end
            bank_we[b] = bo_wr && ({bo.sx[0], bo.sz[0]} == 2'(b));
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        thi_bank u_bank (
            .i_clk   (i_clk),
            .i_en    (adv),
            .i_we    (bank_we[b]),
            .i_addr  (bank_addr[b]),
            .i_wdata (bo.sh),
            .o_rdata (bank_rd[b])
        );
    end

    thi_pkg::t_back r_m;
    thi_pkg::t_tail r_mt;
    logic           r_mv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (adv) begin
            r_mv <= r_bv[NB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m           <= bo;
            r_mt.op       <= bo.op;
            r_mt.status   <= bo.status;
            r_mt.oh       <= bo.oh;
            r_mt.ov       <= bo.ov;
            r_mt.ratio    <= ratio;
        end
    end

    // corner selection and the edge lerp products of both triangle edges
    logic [1:0]              c_p1;
    logic [1:0]              c_q1;
    logic [1:0]              c_p2;
    logic [1:0]              c_q2;
    logic [thi_pkg::H_W-1:0] h_p1;
    logic [thi_pkg::H_W-1:0] h_q1;
    logic [thi_pkg::H_W-1:0] h_p2;
    logic [thi_pkg::H_W-1:0] h_q2;
    logic [thi_pkg::H_W:0]   d1;
    logic [thi_pkg::H_W:0]   d2;
    logic [2*thi_pkg::H_W-7:0] n_prod1;
    logic [2*thi_pkg::H_W-7:0] n_prod2;
    logic [1:0]              par;

    assign par = {r_m.ix[0], r_m.iz[0]};

    always_comb begin
        case (r_m.tri_sel)
            thi_pkg::TRI_ODD_LOW: begin
                c_p1 = thi_pkg::CRN_00; c_q1 = thi_pkg::CRN_10;
                c_p2 = thi_pkg::CRN_01; c_q2 = thi_pkg::CRN_10;
            end
            thi_pkg::TRI_ODD_HIGH: begin
                c_p1 = thi_pkg::CRN_01; c_q1 = thi_pkg::CRN_11;
                c_p2 = thi_pkg::CRN_01; c_q2 = thi_pkg::CRN_10;
            end
            thi_pkg::TRI_EVEN_UPPER: begin
                c_p1 = thi_pkg::CRN_01; c_q1 = thi_pkg::CRN_11;
                c_p2 = thi_pkg::CRN_00; c_q2 = thi_pkg::CRN_11;
            end
            default: begin
                c_p1 = thi_pkg::CRN_00; c_q1 = thi_pkg::CRN_10;
                c_p2 = thi_pkg::CRN_00; c_q2 = thi_pkg::CRN_11;
            end
        endcase
        h_p1 = bank_rd[c_p1 ^ par];
        h_q1 = bank_rd[c_q1 ^ par];
        h_p2 = bank_rd[c_p2 ^ par];
        h_q2 = bank_rd[c_q2 ^ par];
        d1 = {h_q1[thi_pkg::H_W-1], h_q1} - {h_p1[thi_pkg::H_W-1], h_p1};
        d2 = {h_q2[thi_pkg::H_W-1], h_q2} - {h_p2[thi_pkg::H_W-1], h_p2};
        n_prod1 = $signed(d1) * $signed({1'b0, r_m.fx});
        n_prod2 = $signed(d2) * $signed({1'b0, r_m.fx});
    end

    logic [2*thi_pkg::H_W-7:0] r_prod1;
    logic [2*thi_pkg::H_W-7:0] r_prod2;
    logic [thi_pkg::H_W-1:0]   r_p1;
    logic [thi_pkg::H_W-1:0]   r_p2;
    thi_pkg::t_tail            r_lt;
    logic                      r_lv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv <= 1'b0;
        end else if (adv) begin
            r_lv <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod1 <= n_prod1;
            r_prod2 <= n_prod2;
            r_p1    <= h_p1;
            r_p2    <= h_p2;
            r_lt    <= r_mt;
        end
    end

    // edge lerp sums, floor by arithmetic shift
    logic [thi_pkg::H_W:0] s1;
    logic [thi_pkg::H_W:0] s2;

    assign s1 = {r_p1[thi_pkg::H_W-1], r_p1} + r_prod1[40:16];
    assign s2 = {r_p2[thi_pkg::H_W-1], r_p2} + r_prod2[40:16];

    logic [thi_pkg::H_W-1:0] r_e1;
    logic [thi_pkg::H_W-1:0] r_e2;
    thi_pkg::t_tail          r_at;
    logic                    r_av;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (adv) begin
            r_av <= r_lv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e1 <= s1[thi_pkg::H_W-1:0];
            r_e2 <= s2[thi_pkg::H_W-1:0];
            r_at <= r_lt;
        end
    end

    // lerp across the triangle by the ratio
    logic [thi_pkg::H_W:0]    d3;
    logic [2*thi_pkg::H_W-6:0] n_prod3;

    assign d3      = {r_e2[thi_pkg::H_W-1], r_e2} - {r_e1[thi_pkg::H_W-1], r_e1};
    assign n_prod3 = $signed(d3) * $signed({1'b0, r_at.ratio});

    logic [2*thi_pkg::H_W-6:0] r_prod3;
    logic [thi_pkg::H_W-1:0]   r_e;
    thi_pkg::t_tail            r_pt;
    logic                      r_pv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (adv) begin
            r_pv <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod3 <= n_prod3;
            r_e     <= r_e1;
            r_pt    <= r_at;
        end
    end

    // final sum, object compare and result selection
    logic [thi_pkg::H_W:0]   sy;
    logic [thi_pkg::H_W-1:0] y;
    logic                    obj_hi;
    logic [thi_pkg::H_W-1:0] n_height;
    logic [1:0]              n_status;

    assign sy     = {r_e[thi_pkg::H_W-1], r_e} + r_prod3[40:16];
    assign y      = sy[thi_pkg::H_W-1:0];
    assign obj_hi = r_pt.ov && ($signed(r_pt.oh) > $signed(y));

    always_comb begin
        if (r_pt.op == thi_pkg::OP_WRITE) begin
            n_height = '0;
            n_status = thi_pkg::ST_OK;
        end else if (r_pt.status != thi_pkg::ST_OK) begin
            n_height = '0;
            n_status = r_pt.status;
        end else if (obj_hi) begin
            n_height = r_pt.oh;
            n_status = thi_pkg::ST_OBJ;
        end else begin
            n_height = y;
            n_status = thi_pkg::ST_OK;
        end
    end

    // output register
    logic [thi_pkg::H_W-1:0] r_out_height;
    logic [1:0]              r_out_status;
    logic                    r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_height <= n_height;
            r_out_status <= n_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_height;
    assign o_m_tuser  = r_out_status;

endmodule

[test/terrain_height_interpolator_core_test.sv]
// self-checking testbench for terrain_height_interpolator_core: writes grid samples and
// runs height queries under several spacing/size settings, checking against its own predictor
// depends on thi_pkg and the terrain_height_interpolator_core rtl
`timescale 1ns / 1ps

module terrain_height_interpolator_core_test;

    typedef struct {
        logic               op;
        logic [7:0]         sx;
        logic [7:0]         sz;
        logic signed [23:0] sh;
        logic signed [20:0] px;
        logic signed [20:0] pz;
        logic signed [23:0] oh;
        logic               ov;
    } t_item;

    typedef struct {
        logic [23:0] height;
        logic [1:0]  status;
    } t_height_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [111:0] i_s_tdata = '0;
    logic         i_s_tuser = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [23:0]  o_m_tdata;
    logic [1:0]   o_m_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic         i_cfg_index = thi_pkg::CFG_UNIT_DIST;
    logic [15:0]  i_cfg_data = '0;

    terrain_height_interpolator_core uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state and pending traffic
    logic signed [23:0] height_mem [0:65535];
    bit                 sample_seen [0:65535];
    longint             unit_dist_q = 1024;
    longint             map_size_q = 256;
    t_item              item_queue [$];
    t_height_res        expected_heights [$];
    t_item              cur_item;
    logic               s_fire = 1'b0;
    bit                 calm = 1'b0;
    int                 errors = 0;
    int                 n_writes = 0;
    int                 n_status [4] = '{0, 0, 0, 0};

    function automatic longint corner(longint x, longint z);
        return longint'(height_mem[x * 256 + z]);
    endfunction

    function automatic longint lerp_q16(longint a, longint b, longint t);
        return a + (((b - a) * t) >>> 16);
    endfunction

    function automatic longint ratio_q16(longint num, longint den);
        if (den == 0) return 0;
        return (num << 16) / den;
    endfunction

    // expected result of one item; writes update the height store
    function automatic t_height_res predict_height(t_item it);
        t_height_res r;
        longint u, px, pz, ax, az, ms, ix, iz, fx, fz, h1, h2, h3, a, b, y;
        r.height = '0;
        r.status = thi_pkg::ST_OK;
        if (it.op == thi_pkg::OP_WRITE) begin
            height_mem[{it.sx, it.sz}] = it.sh;
            return r;
        end
        u = unit_dist_q;
        if (u == 0) begin
            r.status = thi_pkg::ST_OUT;
            return r;
        end
        px = longint'(it.px);
        pz = longint'(it.pz);
        ax = px < 0 ? -px : px;
        az = pz < 0 ? -pz : pz;
        if ((px < 0 && ax % u != 0) || (pz < 0 && az % u != 0)) begin
            r.status = thi_pkg::ST_NEG;
            return r;
        end
        ms = map_size_q < thi_pkg::MAX_GRID_POINTS ? map_size_q : thi_pkg::MAX_GRID_POINTS;
        ix = ax / u;
        iz = az / u;
        if (px < 0 || pz < 0 || ms < 2 || ix > ms - 2 || iz > ms - 2) begin
            r.status = thi_pkg::ST_OUT;
            return r;
        end
        fx = ((ax % u) << 16) / u;
        fz = ((az % u) << 16) / u;
        if (((ix + iz) & 1) == 1) begin
            h1 = corner(ix, iz + 1);
            h2 = corner(ix + 1, iz);
            if (fx + fz < 65536) begin
                h3 = corner(ix, iz);
                y = lerp_q16(lerp_q16(h3, h2, fx), lerp_q16(h1, h2, fx),
                             ratio_q16(fz, 65536 - fx));
            end else begin
                h3 = corner(ix + 1, iz + 1);
                if (fx == 0) y = h1;
                else y = lerp_q16(lerp_q16(h1, h3, fx), lerp_q16(h1, h2, fx),
                                  ratio_q16(65536 - fz, fx));
            end
        end else if (fz > fx) begin
            h1 = corner(ix, iz + 1);
            h2 = corner(ix + 1, iz + 1);
            h3 = corner(ix, iz);
            y = lerp_q16(lerp_q16(h1, h2, fx), lerp_q16(h3, h2, fx),
                         ratio_q16(65536 - fz, 65536 - fx));
        end else begin
            h1 = corner(ix, iz);
            h2 = corner(ix + 1, iz);
            h3 = corner(ix + 1, iz + 1);
            if (fx == 0) y = h1;
            else y = lerp_q16(lerp_q16(h1, h2, fx), lerp_q16(h1, h3, fx), ratio_q16(fz, fx));
        end
        if (it.ov && longint'(it.oh) > y) begin
            r.height = it.oh;
            r.status = thi_pkg::ST_OBJ;
        end else begin
            r.height = y[23:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // input driver: new transfer or idle at the falling edge
    always @(posedge i_clk) s_fire <= i_s_tvalid && o_s_tready;

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || s_fire)) begin
            if (item_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 29)) begin
                cur_item = item_queue.pop_front();
                i_s_tuser <= cur_item.op;
                i_s_tdata <= {5'd0, cur_item.ov, cur_item.oh, cur_item.pz, cur_item.px,
                              cur_item.sh, cur_item.sz, cur_item.sx};
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // accepted input transfers feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            expected_heights.push_back(predict_height(cur_item));
    end

    // output side: random back-pressure and checking
    always @(negedge i_clk)
        i_m_tready <= i_rst_n && (calm || $urandom_range(0, 99) >= 29);

    always @(posedge i_clk) begin
        t_height_res want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_heights.size() == 0) begin
                report_mismatch("unexpected transfer", o_m_tdata, '0);
            end else begin
                want = expected_heights.pop_front();
                if (o_m_tuser !== want.status)
                    report_mismatch("status", 24'(o_m_tuser), 24'(want.status));
                if (o_m_tdata !== want.height)
                    report_mismatch("height", o_m_tdata, want.height);
                n_status[want.status]++;
            end
        end
    end

    task automatic push_write(int x, int z, logic signed [23:0] h);
        t_item it;
        it = '{thi_pkg::OP_WRITE, x[7:0], z[7:0], h, 21'($urandom), 21'($urandom),
               24'($urandom), 1'($urandom)};
        sample_seen[x * 256 + z] = 1'b1;
        item_queue.push_back(it);
        n_writes++;
    endtask

    // queue the query, writing any unwritten corner of an in-grid cell first
    task automatic push_query(longint px, longint pz, logic signed [23:0] oh, logic ov);
        t_item it;
        longint ix, iz, ms;
        ms = map_size_q < thi_pkg::MAX_GRID_POINTS ? map_size_q : thi_pkg::MAX_GRID_POINTS;
        if (px >= 0 && pz >= 0) begin
            ix = px / unit_dist_q;
            iz = pz / unit_dist_q;
            if (ix <= ms - 2 && iz <= ms - 2)
                for (int dx = 0; dx < 2; dx++)
                    for (int dz = 0; dz < 2; dz++)
                        if (!sample_seen[(ix + dx) * 256 + iz + dz])
                            push_write(int'(ix + dx), int'(iz + dz), 24'($urandom));
        end
        it = '{thi_pkg::OP_QUERY, 8'($urandom), 8'($urandom), 24'($urandom), px[20:0],
               pz[20:0], oh, ov};
        item_queue.push_back(it);
    endtask

    // one coordinate: inside the usable grid, negative with fraction, negative whole, or wild
    function automatic longint pick_coord(int kind);
        longint u, ms, top, k, r;
        u = unit_dist_q;
        ms = map_size_q < thi_pkg::MAX_GRID_POINTS ? map_size_q : thi_pkg::MAX_GRID_POINTS;
        case (kind)
            0: begin
                top = (1048575 - (u - 1)) / u;
                if (top > ms - 2) top = ms - 2;
                k = $urandom_range(0, top);
                return k * u + $urandom_range(0, u - 1);
            end
            1: begin
                if (u < 2) return -longint'($urandom_range(0, 1048576));
                r = $urandom_range(1, u - 1);
                k = $urandom_range(0, (1048576 - r) / u);
                return -(k * u + r);
            end
            2: return -(longint'($urandom_range(0, 1048576 / u)) * u);
            default: return longint'($signed(21'($urandom)));
        endcase
    endfunction

    task automatic push_random(int n);
        int sel, kx, kz;
        repeat (n) begin
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                push_write($urandom_range(0, 255), $urandom_range(0, 255), 24'($urandom));
            end else begin
                sel = $urandom_range(0, 99);
                kx = sel < 70 ? 0 : sel < 80 ? 1 : sel < 87 ? 2 : 3;
                sel = $urandom_range(0, 99);
                kz = sel < 80 ? 0 : sel < 88 ? 1 : sel < 94 ? 2 : 3;
                push_query(pick_coord(kx), pick_coord(kz), 24'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic drain();
        while (item_queue.size() > 0 || i_s_tvalid || expected_heights.size() > 0)
            @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == thi_pkg::CFG_UNIT_DIST) unit_dist_q = val;
        else map_size_q = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(logic [15:0] ud, logic [15:0] ms, int n);
        drain();
        write_reg(thi_pkg::CFG_UNIT_DIST, ud);
        write_reg(thi_pkg::CFG_MAP_SIZE, ms);
        push_random(n);
    endtask

    // stimulus
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset spacing 1024, no idling on either side
        calm = 1'b1;
        push_write(0, 0, 24'sh7FFFFF);
        push_write(1, 0, -24'sh800000);
        push_write(0, 1, 24'sh001000);
        push_write(1, 1, -24'sh000100);
        push_write(2, 0, 24'sh123456);
        push_write(2, 1, 24'sh7FFFFF);
        push_write(255, 255, -24'sh800000);
        push_query(300, 700, 24'sh0, 1'b0);                // even cell, upper triangle
        push_query(700, 300, 24'sh0, 1'b0);                // even cell, lower triangle
        push_query(0, 500, 24'sh0, 1'b0);                  // even cell, x on the edge
        push_query(1024 + 200, 300, 24'sh0, 1'b0);         // odd cell, near triangle
        push_query(1024 + 900, 800, 24'sh0, 1'b0);         // odd cell, far triangle
        push_query(1023, 1023, 24'sh0, 1'b0);
        push_query(500, 500, 24'sh7FFFFF, 1'b1);           // object above terrain
        push_query(500, 500, -24'sh800000, 1'b1);          // object below terrain
        push_query(500, 500, 24'sh7FFFFF, 1'b0);           // object flag clear
        push_query(-5, 100, 24'sh0, 1'b0);                 // negative fraction
        push_query(100, -1048576, 24'sh0, 1'b0);           // negative whole multiple
        push_query(1048575, 100, 24'sh0, 1'b0);            // beyond the grid
        push_query(254 * 1024 + 1023, 254 * 1024, 24'sh0, 1'b0);
        push_random(150);
        drain();
        calm = 1'b0;
        push_random(50);

        // sender holds off until everything is back, then new settings each phase
        run_phase(16'd1, 16'd2, 100);
        run_phase(16'd65535, 16'd256, 150);
        run_phase(16'd256, 16'd256, 150);
        run_phase(16'd3, 16'd17, 100);
        for (int p = 0; p < 3; p++)
            run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(2, 256)), 70);
        drain();

        $display("covered %0d sample writes and %0d queries over 8 spacing/size settings",
                 n_writes, n_status[0] + n_status[1] + n_status[2] + n_status[3] - n_writes);
        $display("status counts: ok %0d, object %0d, negative %0d, outside %0d",
                 n_status[0] - n_writes, n_status[1], n_status[2], n_status[3]);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
rtl/thi_pkg.sv
rtl/thi_coord_div.sv
rtl/thi_ratio_div.sv
rtl/thi_bank.sv
rtl/terrain_height_interpolator_core.sv
test/terrain_height_interpolator_core_test.sv
